// ===== hw/rtl/hrck_pkg.sv =====
// Shared constants, types and pipeline records for the hue range chroma keyer.
package hrck_pkg;

  localparam int CHANNEL_BITS    = 8;
  localparam int HUE_W           = 15;
  localparam int HUE_SIXTH       = 3840;
  localparam int HUE_FULL        = 6 * HUE_SIXTH;
  localparam int QUO_W           = 12;
  localparam int NUM_W           = CHANNEL_BITS + QUO_W;
  localparam int DIV_STAGES      = 4;
  localparam int STEPS_PER_STAGE = QUO_W / DIV_STAGES;
  localparam int PIPE_DEPTH      = DIV_STAGES + 4;
  localparam int CFG_IDX_W       = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HUE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HUE = CFG_IDX_W'(1);

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    chan_t   red;
    chan_t   green;
    chan_t   blue;
    sector_t sector;
    logic    neg;
    logic    undef;
  } side_t;

  typedef struct packed {
    chan_t              rem;
    logic [QUO_W-1:0]   num_lo;
    logic [QUO_W-1:0]   quo;
    chan_t              den;
  } div_stage_t;

endpackage

// ===== hw/rtl/hue_range_chroma_key_core.sv =====
// Top level of the hue range chroma keyer: sector decode, divider, hue wrap and key decision.
// The keyer takes one pixel in every clock cycle while busy is low and returns its result
// through a registered pipeline: the four-stage quotient divider plus two stages ahead of it
// and two behind it. The result is shown for one cycle with out_valid high
// and cannot be held off, so the receiver must take every result as it appears. busy is high
// only during reset and in the cycle after it. Pixels whose hue lies strictly between min_hue
// and max_hue come out with alpha and color all zero; grey and black pixels always pass.
module hue_range_chroma_key_core import hrck_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  chan_t                in_red,
  input  chan_t                in_green,
  input  chan_t                in_blue,
  output logic                 out_valid,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic [7:0]           out_alpha,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HUE_W-1:0]     cfg_data
);

  logic             busy_r;
  logic             in_fire;
  logic [HUE_W-1:0] min_hue_r;
  logic [HUE_W-1:0] max_hue_r;

  chan_t            hi;
  chan_t            lo;
  side_t            s1_side_nxt;
  chan_t            s1_abs_nxt;
  logic             s1_vld_r;
  side_t            s1_side_r;
  chan_t            s1_abs_r;
  chan_t            s1_spread_r;

  logic [CHANNEL_BITS+3:0] num15;
  logic             s2_vld_r;
  side_t            s2_side_r;
  logic [NUM_W-1:0] s2_num_r;
  chan_t            s2_den_r;

  logic             dv_valid;
  logic [QUO_W-1:0] dv_quo;
  logic             dv_rem_nz;
  side_t            dv_side;

  logic [QUO_W:0]          qmag;
  logic signed [HUE_W+1:0] off;
  logic signed [HUE_W+1:0] qs;
  logic signed [HUE_W+1:0] hue_s;
  logic [HUE_W-1:0]        hue_nxt;
  logic             h_vld_r;
  logic [HUE_W-1:0] hue_r;
  side_t            h_side_r;

  logic             keyed;
  logic             out_valid_r;
  logic [7:0]       out_red_r;
  logic [7:0]       out_green_r;
  logic [7:0]       out_blue_r;
  logic [7:0]       out_alpha_r;

  assign busy    = busy_r | !rst_n;
  assign in_fire = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      min_hue_r <= '0;
      max_hue_r <= '0;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_HUE: min_hue_r <= cfg_data;
          CFG_MAX_HUE: max_hue_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // The red channel wins ties for the largest value, then green.
  always_comb begin
    hi = in_red;
    lo = in_red;
    if (in_green > hi) hi = in_green;
    if (in_blue > hi) hi = in_blue;
    if (in_green < lo) lo = in_green;
    if (in_blue < lo) lo = in_blue;
    s1_side_nxt.red   = in_red;
    s1_side_nxt.green = in_green;
    s1_side_nxt.blue  = in_blue;
    s1_side_nxt.undef = (hi == lo);
    if (in_red == hi) begin
      s1_side_nxt.sector = SEC_RED;
      s1_side_nxt.neg    = in_green < in_blue;
      s1_abs_nxt = s1_side_nxt.neg ? in_blue - in_green : in_green - in_blue;
    end else if (in_green == hi) begin
      s1_side_nxt.sector = SEC_GREEN;
      s1_side_nxt.neg    = in_blue < in_red;
      s1_abs_nxt = s1_side_nxt.neg ? in_red - in_blue : in_blue - in_red;
    end else begin
      s1_side_nxt.sector = SEC_BLUE;
      s1_side_nxt.neg    = in_red < in_green;
      s1_abs_nxt = s1_side_nxt.neg ? in_green - in_red : in_red - in_green;
    end
  end

  // The numerator is 3840 times the difference, built as fifteen times it shifted by eight.
  assign num15 = {s1_abs_r, 4'b0000} - {4'b0000, s1_abs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      h_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= in_fire;
      s2_vld_r    <= s1_vld_r;
      h_vld_r     <= dv_valid;
      out_valid_r <= h_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_side_r   <= s1_side_nxt;
    s1_abs_r    <= s1_abs_nxt;
    s1_spread_r <= hi - lo;
    s2_side_r   <= s1_side_r;
    s2_num_r    <= {num15, 8'h00};
    s2_den_r    <= s1_spread_r;
  end

  hrck_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_vld_r),
    .in_num    (s2_num_r),
    .in_den    (s2_den_r),
    .in_side   (s2_side_r),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_rem_nz(dv_rem_nz),
    .out_side  (dv_side)
  );

  // A negative difference with a remainder rounds one further down.
  always_comb begin
    qmag = {1'b0, dv_quo} + (QUO_W+1)'(dv_side.neg & dv_rem_nz);
    qs   = $signed((HUE_W+2)'(qmag));
    case (dv_side.sector)
      SEC_RED:   off = '0;
      SEC_GREEN: off = (HUE_W+2)'(2 * HUE_SIXTH);
      SEC_BLUE:  off = (HUE_W+2)'(4 * HUE_SIXTH);
      default:   off = '0;
    endcase
    hue_s = dv_side.neg ? off - qs : off + qs;
    if (hue_s < 0) begin
      hue_s = hue_s + $signed((HUE_W+2)'(HUE_FULL));
    end
    hue_nxt = hue_s[HUE_W-1:0];
  end

  assign keyed = !h_side_r.undef && (hue_r > min_hue_r) && (hue_r < max_hue_r);

  always_ff @(posedge clk) begin
    hue_r    <= hue_nxt;
    h_side_r <= dv_side;
    if (keyed) begin
      out_red_r   <= '0;
      out_green_r <= '0;
      out_blue_r  <= '0;
      out_alpha_r <= '0;
    end else begin
      out_red_r   <= 8'(h_side_r.red);
      out_green_r <= 8'(h_side_r.green);
      out_blue_r  <= 8'(h_side_r.blue);
      out_alpha_r <= 8'({CHANNEL_BITS{1'b1}});
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;
  assign out_alpha = out_alpha_r;

  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> ##PIPE_DEPTH out_valid)
    else $error("accepted item did not produce a result");

  a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_fire, PIPE_DEPTH))
    else $error("result without a matching accepted item");

  a_keyed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_alpha == 8'h00) |-> (out_red == 8'h00 && out_green == 8'h00 &&
      out_blue == 8'h00))
    else $error("keyed item carries nonzero color");

  a_grey_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_red == out_green && out_green == out_blue && out_red != 8'h00)
      |-> out_alpha != 8'h00)
    else $error("grey item was keyed");

endmodule

// ===== hw/rtl/hrck_div.sv =====
// Pipelined restoring divider that forms the hue quotient a few bits per stage.
module hrck_div import hrck_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  chan_t            in_den,
  input  side_t            in_side,
  output logic             out_valid,
  output logic [QUO_W-1:0] out_quo,
  output logic             out_rem_nz,
  output side_t            out_side
);

  logic       vld_r  [DIV_STAGES];
  div_stage_t st_r   [DIV_STAGES];
  side_t      side_r [DIV_STAGES];
  div_stage_t st_in  [DIV_STAGES];
  div_stage_t st_nxt [DIV_STAGES];

  always_comb begin
    div_stage_t            cur;
    logic [CHANNEL_BITS:0] trial;
    st_in[0].rem    = in_num[NUM_W-1:QUO_W];
    st_in[0].num_lo = in_num[QUO_W-1:0];
    st_in[0].quo    = '0;
    st_in[0].den    = in_den;
    for (int s = 1; s < DIV_STAGES; s++) begin
      st_in[s] = st_r[s-1];
    end
    for (int s = 0; s < DIV_STAGES; s++) begin
      cur = st_in[s];
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        trial      = {cur.rem, cur.num_lo[QUO_W-1]};
        cur.num_lo = {cur.num_lo[QUO_W-2:0], 1'b0};
        if (trial >= {1'b0, cur.den}) begin
          cur.rem = CHANNEL_BITS'(trial - {1'b0, cur.den});
          cur.quo = {cur.quo[QUO_W-2:0], 1'b1};
        end else begin
          cur.rem = trial[CHANNEL_BITS-1:0];
          cur.quo = {cur.quo[QUO_W-2:0], 1'b0};
        end
      end
      st_nxt[s] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_valid;
      for (int s = 1; s < DIV_STAGES; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    for (int s = 1; s < DIV_STAGES; s++) begin
      side_r[s] <= side_r[s-1];
    end
    for (int s = 0; s < DIV_STAGES; s++) begin
      st_r[s] <= st_nxt[s];
    end
  end

  assign out_valid  = vld_r[DIV_STAGES-1];
  assign out_quo    = st_r[DIV_STAGES-1].quo;
  assign out_rem_nz = |st_r[DIV_STAGES-1].rem;
  assign out_side   = side_r[DIV_STAGES-1];

endmodule
